[rtl/swdh_pkg.sv]
// Shared types and constants for the SWD host transaction engine.
package swdh_pkg;

  // Width of the bit counter within one phase of a sequence.
  localparam int unsigned COUNT_W = 7;

  // Width of the data shifter: 32 data bits and a parity bit.
  localparam int unsigned SHIFT_W = 33;

  // Value of the retry limit register after reset.
  localparam logic [15:0] RETRY_RESET = 16'd600;

  // Item operations.
  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_START      = 2'd1,
    OP_LINE_RESET = 2'd2,
    OP_UNUSED     = 2'd3
  } op_t;

  // Acknowledge codes as received, first bit in the LSB.
  localparam logic [2:0] ACK_OK   = 3'd1;
  localparam logic [2:0] ACK_WAIT = 3'd2;

  // Phases of a transaction or line reset sequence.
  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_HDR   = 4'd1,
    PH_TRN_A = 4'd2,
    PH_ACK   = 4'd3,
    PH_TRN_B = 4'd4,
    PH_WDATA = 4'd5,
    PH_RDATA = 4'd6,
    PH_TRN_C = 4'd7,
    PH_SW    = 4'd8,
    PH_HI    = 4'd9,
    PH_LO    = 4'd10
  } phase_t;

  // Step that follows the turnaround after the acknowledge.
  typedef enum logic [1:0] {
    NEXT_HDR   = 2'd0,
    NEXT_DONE  = 2'd1,
    NEXT_WDATA = 2'd2,
    NEXT_RDATA = 2'd3
  } after_t;

  // One input item.
  typedef struct packed {
    logic [1:0]  op;
    logic        ap_ndp;
    logic        read_not_write;
    logic [1:0]  reg_addr;
    logic [31:0] write_data;
    logic        stop_on_error;
    logic        swdio_in;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic        swdio_out;
    logic        swdio_drive;
    logic        busy_res;
    logic        done_res;
    logic [2:0]  ack_code;
    logic [31:0] read_data;
    logic        parity_error;
  } out_item_t;

endpackage

[rtl/swd_host_transaction_engine_top.sv]
// SWD host transaction engine: header, acknowledge, data phases and line reset.
// Throughput: one item per cycle unless a result waits with out_ready low; the phase
// sequencer steps once per accepted item, whose result goes to the output register.
// A new item is taken while the previous result waits, as long as out_ready frees it.
// Reset (rst_n low, synchronous) returns the sequencer to idle, clears the status
// and sets the retry limit to 600.
module swd_host_transaction_engine_top #(
  parameter int unsigned RESET_HIGH_BITS = 50,
  parameter int unsigned SWITCH_CODE     = 59294
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  swdh_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output swdh_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);
  import swdh_pkg::*;

  localparam logic [15:0]        SW_CODE = 16'(SWITCH_CODE);
  localparam logic [COUNT_W-1:0] HI_LAST = COUNT_W'(RESET_HIGH_BITS);

  // Sequencer state.
  phase_t              phase_r, phase_nxt;
  logic [COUNT_W-1:0]  bit_count_r, bit_count_nxt;
  logic [SHIFT_W-1:0]  shift_word_r, shift_word_nxt;
  logic [7:0]          header_byte_r, header_byte_nxt;
  logic [2:0]          ack_reg_r, ack_reg_nxt;
  logic [15:0]         retry_left_r, retry_left_nxt;
  logic                is_read_r, is_read_nxt;
  logic                halt_on_error_r, halt_on_error_nxt;
  logic                running_parity_r, running_parity_nxt;
  logic [31:0]         read_word_r, read_word_nxt;
  logic                perr_r, perr_nxt;
  after_t              after_trn_r, after_trn_nxt;
  logic [15:0]         max_retries_r;

  // Output register.
  logic                out_valid_r;
  out_item_t           out_data_r;
  out_item_t           res;

  logic                accept;
  logic                done;
  logic [COUNT_W-1:0]  bc_inc;
  logic [SHIFT_W-1:0]  ack_word;
  logic [1:0]          line_cur;
  logic [1:0]          line_new;
  op_t                 op;

  // Line level for a phase: {bit driven, drive enable}.
  function automatic logic [1:0] line_of(
    input phase_t             ph,
    input logic [COUNT_W-1:0] bc,
    input logic [SHIFT_W-1:0] sw,
    input logic [7:0]         hb
  );
    logic bit_v;
    logic drv;
    bit_v = 1'b0;
    drv   = 1'b1;
    case (ph)
      PH_HDR:   bit_v = hb[bc[2:0]];
      PH_WDATA: bit_v = (bc < COUNT_W'(SHIFT_W)) ? sw[bc[5:0]] : 1'b0;
      PH_SW:    bit_v = (bc < COUNT_W'(16)) ? SW_CODE[bc[3:0]] : 1'b0;
      PH_HI:    bit_v = 1'b1;
      PH_LO, PH_IDLE: bit_v = 1'b0;
      default:  drv = 1'b0;
    endcase
    return {bit_v, drv};
  endfunction

  assign op        = op_t'(in_data.op);
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign bc_inc    = bit_count_r + COUNT_W'(1);

  // Acknowledge shifter with the current line bit merged in.
  always_comb begin
    ack_word = shift_word_r;
    ack_word[bit_count_r[1:0]] = shift_word_r[bit_count_r[1:0]] | in_data.swdio_in;
  end

  // Next state of the sequencer for one item.
  always_comb begin
    phase_nxt          = phase_r;
    bit_count_nxt      = bit_count_r;
    shift_word_nxt     = shift_word_r;
    header_byte_nxt    = header_byte_r;
    ack_reg_nxt        = ack_reg_r;
    retry_left_nxt     = retry_left_r;
    is_read_nxt        = is_read_r;
    halt_on_error_nxt  = halt_on_error_r;
    running_parity_nxt = running_parity_r;
    read_word_nxt      = read_word_r;
    perr_nxt           = perr_r;
    after_trn_nxt      = after_trn_r;
    done               = 1'b0;

    case (op)
      OP_TICK: begin
        if (phase_r != PH_IDLE) begin
          case (phase_r)
            PH_HDR: begin
              bit_count_nxt = bc_inc;
              if (bc_inc >= COUNT_W'(8)) begin
                phase_nxt     = PH_TRN_A;
                bit_count_nxt = '0;
              end
            end
            PH_TRN_A: begin
              phase_nxt      = PH_ACK;
              bit_count_nxt  = '0;
              shift_word_nxt = '0;
            end
            PH_ACK: begin
              shift_word_nxt = ack_word;
              bit_count_nxt  = bc_inc;
              if (bc_inc >= COUNT_W'(3)) begin
                ack_reg_nxt   = ack_word[2:0];
                bit_count_nxt = '0;
                phase_nxt     = PH_TRN_B;
                if (ack_word[2:0] == ACK_WAIT && retry_left_r != 16'd0) begin
                  retry_left_nxt = retry_left_r - 16'd1;
                  after_trn_nxt  = NEXT_HDR;
                end else if (ack_word[2:0] != ACK_OK && halt_on_error_r) begin
                  after_trn_nxt = NEXT_DONE;
                end else if (!is_read_r) begin
                  after_trn_nxt = NEXT_WDATA;
                end else if (ack_word[2:0] == ACK_WAIT) begin
                  after_trn_nxt = NEXT_RDATA;
                end else begin
                  phase_nxt          = PH_RDATA;
                  shift_word_nxt     = '0;
                  running_parity_nxt = 1'b0;
                end
              end
            end
            PH_TRN_B: begin
              bit_count_nxt = '0;
              case (after_trn_r)
                NEXT_HDR:   phase_nxt = PH_HDR;
                NEXT_WDATA: phase_nxt = PH_WDATA;
                NEXT_RDATA: begin
                  phase_nxt          = PH_RDATA;
                  shift_word_nxt     = '0;
                  running_parity_nxt = 1'b0;
                end
                default: begin
                  phase_nxt = PH_IDLE;
                  done      = 1'b1;
                end
              endcase
            end
            PH_WDATA: begin
              bit_count_nxt = bc_inc;
              if (bc_inc >= COUNT_W'(SHIFT_W)) begin
                phase_nxt     = PH_IDLE;
                bit_count_nxt = '0;
                done          = 1'b1;
              end
            end
            PH_RDATA: begin
              if (bit_count_r < COUNT_W'(32)) begin
                shift_word_nxt[bit_count_r[4:0]] =
                  shift_word_r[bit_count_r[4:0]] | in_data.swdio_in;
                running_parity_nxt = running_parity_r ^ in_data.swdio_in;
                bit_count_nxt      = bc_inc;
              end else begin
                read_word_nxt = shift_word_r[31:0];
                perr_nxt      = in_data.swdio_in != running_parity_r;
                phase_nxt     = PH_TRN_C;
                bit_count_nxt = '0;
              end
            end
            PH_TRN_C: begin
              phase_nxt     = PH_IDLE;
              bit_count_nxt = '0;
              done          = 1'b1;
            end
            PH_SW: begin
              bit_count_nxt = bc_inc;
              if (bc_inc >= COUNT_W'(16)) begin
                phase_nxt     = PH_HI;
                bit_count_nxt = '0;
              end
            end
            PH_HI: begin
              bit_count_nxt = bc_inc;
              if (bc_inc >= HI_LAST) begin
                phase_nxt     = PH_LO;
                bit_count_nxt = '0;
              end
            end
            PH_LO: begin
              bit_count_nxt = bc_inc;
              if (bc_inc >= COUNT_W'(2)) begin
                phase_nxt     = PH_IDLE;
                bit_count_nxt = '0;
                done          = 1'b1;
              end
            end
            default: begin
              phase_nxt     = PH_IDLE;
              bit_count_nxt = '0;
            end
          endcase
        end
      end
      OP_START: begin
        if (phase_r == PH_IDLE) begin
          header_byte_nxt = {1'b1, 1'b0,
                             in_data.ap_ndp ^ in_data.read_not_write ^ (^in_data.reg_addr),
                             in_data.reg_addr[1], in_data.reg_addr[0],
                             in_data.read_not_write, in_data.ap_ndp, 1'b1};
          shift_word_nxt     = {^in_data.write_data, in_data.write_data};
          is_read_nxt        = in_data.read_not_write;
          halt_on_error_nxt  = in_data.stop_on_error;
          retry_left_nxt     = max_retries_r;
          running_parity_nxt = 1'b0;
          perr_nxt           = 1'b0;
          phase_nxt          = PH_HDR;
          bit_count_nxt      = '0;
        end
      end
      OP_LINE_RESET: begin
        if (phase_r == PH_IDLE) begin
          phase_nxt     = PH_SW;
          bit_count_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  // Line as clocked on a tick, or as it stands after any other item.
  assign line_cur = line_of(phase_r, bit_count_r, shift_word_r, header_byte_r);
  assign line_new = line_of(phase_nxt, bit_count_nxt, shift_word_nxt, header_byte_nxt);

  // Result item for this item.
  always_comb begin
    res              = '0;
    res.swdio_out    = (op == OP_TICK) ? line_cur[1] : line_new[1];
    res.swdio_drive  = (op == OP_TICK) ? line_cur[0] : line_new[0];
    res.busy_res     = phase_nxt != PH_IDLE;
    res.done_res     = done;
    res.ack_code     = ack_reg_nxt;
    res.read_data    = read_word_nxt;
    res.parity_error = perr_nxt;
  end

  // Sequencer and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_IDLE;
      bit_count_r      <= '0;
      shift_word_r     <= '0;
      header_byte_r    <= '0;
      ack_reg_r        <= '0;
      retry_left_r     <= '0;
      is_read_r        <= 1'b0;
      halt_on_error_r  <= 1'b0;
      running_parity_r <= 1'b0;
      read_word_r      <= '0;
      perr_r           <= 1'b0;
      after_trn_r      <= NEXT_HDR;
      max_retries_r    <= RETRY_RESET;
    end else begin
      if (accept) begin
        phase_r          <= phase_nxt;
        bit_count_r      <= bit_count_nxt;
        shift_word_r     <= shift_word_nxt;
        header_byte_r    <= header_byte_nxt;
        ack_reg_r        <= ack_reg_nxt;
        retry_left_r     <= retry_left_nxt;
        is_read_r        <= is_read_nxt;
        halt_on_error_r  <= halt_on_error_nxt;
        running_parity_r <= running_parity_nxt;
        read_word_r      <= read_word_nxt;
        perr_r           <= perr_nxt;
        after_trn_r      <= after_trn_nxt;
      end
      if (cfg_valid) begin
        max_retries_r <= cfg_data;
      end
    end
  end

  // Output register: holds a result item until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

endmodule

[tb/sv/swdh_line_checker.sv]
// Checker for the SWD host engine: follows the line sequencer and compares every result item.
`timescale 1ns / 1ps

module swdh_line_checker #(
  parameter int unsigned HIGH_BITS = 50,
  parameter int unsigned SW_CODE   = 59294
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  swdh_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  swdh_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [15:0]         cfg_data,
  output int unsigned         fails,
  output int unsigned         waiting
);
  import swdh_pkg::*;

  localparam logic [15:0] SW_BITS = 16'(SW_CODE);
  localparam logic [6:0]  HI_LAST = 7'(HIGH_BITS);

  // Own copy of the sequencer state and the retry limit.
  phase_t      ln_phase;
  logic [6:0]  ln_count;
  logic [32:0] ln_shift;
  logic [7:0]  ln_header;
  logic [2:0]  ln_ack;
  logic [15:0] ln_retries;
  logic        ln_read;
  logic        ln_halt;
  logic        ln_par;
  logic [31:0] ln_word;
  logic        ln_perr;
  after_t      ln_next;
  logic [15:0] retry_limit;

  // Result items predicted but not yet seen, oldest first.
  out_item_t predicted_lines[$];

  task automatic reset_line();
    ln_phase    = PH_IDLE;
    ln_count    = '0;
    ln_shift    = '0;
    ln_header   = '0;
    ln_ack      = '0;
    ln_retries  = '0;
    ln_read     = 1'b0;
    ln_halt     = 1'b0;
    ln_par      = 1'b0;
    ln_word     = '0;
    ln_perr     = 1'b0;
    ln_next     = NEXT_HDR;
    retry_limit = RETRY_RESET;
  endtask

  task automatic enter_phase(input phase_t p);
    ln_phase = p;
    ln_count = '0;
  endtask

  task automatic start_read_data();
    enter_phase(PH_RDATA);
    ln_shift = '0;
    ln_par   = 1'b0;
  endtask

  // Level the host presents on SWDIO in the current phase.
  task automatic drive_level(output logic lvl, output logic drv);
    lvl = 1'b0;
    drv = 1'b1;
    case (ln_phase)
      PH_HDR:         lvl = ln_header[ln_count[2:0]];
      PH_WDATA:       lvl = (ln_count < 7'd33) ? ln_shift[ln_count[5:0]] : 1'b0;
      PH_SW:          lvl = (ln_count < 7'd16) ? SW_BITS[ln_count[3:0]] : 1'b0;
      PH_HI:          lvl = 1'b1;
      PH_LO, PH_IDLE: ;
      default:        drv = 1'b0;
    endcase
  endtask

  // One SWCLK period of the sequencer; fin is set on the closing tick.
  task automatic clock_line(input logic din, output logic fin);
    fin = 1'b0;
    case (ln_phase)
      PH_HDR: begin
        ln_count = ln_count + 7'd1;
        if (ln_count >= 7'd8) enter_phase(PH_TRN_A);
      end
      PH_TRN_A: begin
        enter_phase(PH_ACK);
        ln_shift = '0;
      end
      PH_ACK: begin
        ln_shift[ln_count[1:0]] = ln_shift[ln_count[1:0]] | din;
        ln_count = ln_count + 7'd1;
        if (ln_count >= 7'd3) begin
          ln_ack = ln_shift[2:0];
          // A WAIT with retries left resends the header; otherwise the ack is final.
          if (ln_ack == ACK_WAIT && ln_retries != 16'd0) begin
            ln_retries = ln_retries - 16'd1;
            ln_next = NEXT_HDR;
            enter_phase(PH_TRN_B);
          end else if (ln_ack != ACK_OK && ln_halt) begin
            ln_next = NEXT_DONE;
            enter_phase(PH_TRN_B);
          end else if (!ln_read) begin
            ln_next = NEXT_WDATA;
            enter_phase(PH_TRN_B);
          end else if (ln_ack == ACK_WAIT) begin
            ln_next = NEXT_RDATA;
            enter_phase(PH_TRN_B);
          end else begin
            start_read_data();
          end
        end
      end
      PH_TRN_B: begin
        case (ln_next)
          NEXT_HDR:   enter_phase(PH_HDR);
          NEXT_WDATA: enter_phase(PH_WDATA);
          NEXT_RDATA: start_read_data();
          default: begin
            enter_phase(PH_IDLE);
            fin = 1'b1;
          end
        endcase
      end
      PH_WDATA: begin
        ln_count = ln_count + 7'd1;
        if (ln_count >= 7'd33) begin
          enter_phase(PH_IDLE);
          fin = 1'b1;
        end
      end
      PH_RDATA: begin
        // Thirty-two data bits, then the parity bit is judged.
        if (ln_count < 7'd32) begin
          ln_shift[ln_count[4:0]] = ln_shift[ln_count[4:0]] | din;
          ln_par = ln_par ^ din;
          ln_count = ln_count + 7'd1;
        end else begin
          ln_word = ln_shift[31:0];
          ln_perr = (din != ln_par);
          enter_phase(PH_TRN_C);
        end
      end
      PH_TRN_C: begin
        enter_phase(PH_IDLE);
        fin = 1'b1;
      end
      PH_SW: begin
        ln_count = ln_count + 7'd1;
        if (ln_count >= 7'd16) enter_phase(PH_HI);
      end
      PH_HI: begin
        ln_count = ln_count + 7'd1;
        if (ln_count >= HI_LAST) enter_phase(PH_LO);
      end
      PH_LO: begin
        ln_count = ln_count + 7'd1;
        if (ln_count >= 7'd2) begin
          enter_phase(PH_IDLE);
          fin = 1'b1;
        end
      end
      default: enter_phase(PH_IDLE);
    endcase
  endtask

  // Works out the result item that one input item causes.
  task automatic predict_line(input in_item_t it, output out_item_t res);
    logic lvl;
    logic drv;
    logic fin;
    fin = 1'b0;
    if (it.op == OP_TICK) begin
      // The line reflects the bit clocked in this tick, before the step.
      drive_level(lvl, drv);
      if (ln_phase != PH_IDLE) clock_line(it.swdio_in, fin);
    end else begin
      // Starts and line resets are taken only while idle; anything else leaves the state alone.
      if (ln_phase == PH_IDLE && it.op == OP_START) begin
        ln_header  = {1'b1, 1'b0, ^{it.ap_ndp, it.read_not_write, it.reg_addr},
                      it.reg_addr[1], it.reg_addr[0], it.read_not_write, it.ap_ndp, 1'b1};
        ln_shift   = {^it.write_data, it.write_data};
        ln_read    = it.read_not_write;
        ln_halt    = it.stop_on_error;
        ln_retries = retry_limit;
        ln_par     = 1'b0;
        ln_perr    = 1'b0;
        enter_phase(PH_HDR);
      end else if (ln_phase == PH_IDLE && it.op == OP_LINE_RESET) begin
        enter_phase(PH_SW);
      end
      drive_level(lvl, drv);
    end
    res.swdio_out    = lvl;
    res.swdio_drive  = drv;
    res.busy_res     = (ln_phase != PH_IDLE);
    res.done_res     = fin;
    res.ack_code     = ln_ack;
    res.read_data    = ln_word;
    res.parity_error = ln_perr;
  endtask

  task automatic compare_field(input string tag, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, tag, want, got);
      fails++;
    end
  endtask

  // Watch all three channels at each rising edge.
  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t fresh;
    if (!rst_n) begin
      reset_line();
      predicted_lines.delete();
    end else begin
      if (cfg_valid && cfg_ready) retry_limit = cfg_data;
      if (in_valid && in_ready) begin
        predict_line(in_data, fresh);
        predicted_lines.push_back(fresh);
      end
      if (out_valid && out_ready) begin
        if (predicted_lines.size() == 0) begin
          $display("%0t: result item with none predicted: actual %h", $time, out_data);
          fails++;
        end else begin
          want = predicted_lines.pop_front();
          compare_field("swdio_out", 32'(want.swdio_out), 32'(out_data.swdio_out));
          compare_field("swdio_drive", 32'(want.swdio_drive), 32'(out_data.swdio_drive));
          compare_field("busy_res", 32'(want.busy_res), 32'(out_data.busy_res));
          compare_field("done_res", 32'(want.done_res), 32'(out_data.done_res));
          compare_field("ack_code", 32'(want.ack_code), 32'(out_data.ack_code));
          compare_field("read_data", want.read_data, out_data.read_data);
          compare_field("parity_error", 32'(want.parity_error),
                        32'(out_data.parity_error));
        end
      end
    end
    waiting <= predicted_lines.size();
  end

endmodule

[tb/sv/tb.sv]
// Testbench top: feeds SWD host items and retry limit writes, then gives the verdict.
`timescale 1ns / 1ps

module tb;
  import swdh_pkg::*;

  localparam int unsigned HIGH_BITS    = 50;
  localparam int unsigned SW_CODE      = 59294;
  localparam int          ITEM_TARGET  = 850;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          CHOKE_CYCLES = 300;
  localparam int          MAX_GAP      = 16;
  localparam logic [2:0]  ACK_FAULT    = 3'd4;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  int unsigned fails;
  int unsigned waiting;

  int          cycles = 0;
  logic        flood;          // asks the drain side for one long hold-off
  logic [15:0] retry_cfg;
  logic [15:0] retry_plan [6];
  int          counted;
  bit          send_calm;

  swd_host_transaction_engine_top #(
    .RESET_HIGH_BITS(HIGH_BITS),
    .SWITCH_CODE    (SW_CODE)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  swdh_line_checker #(
    .HIGH_BITS(HIGH_BITS),
    .SW_CODE  (SW_CODE)
  ) i_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .fails    (fails),
    .waiting  (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** swd_host_transaction_engine_top: FAILED **");
      $finish;
    end
  end

  // Result side: a random stall before each item, calm stretches, and one long hold-off.
  initial begin : drain
    int stall;
    int taken;
    bit calm;
    bit choked;
    taken  = 0;
    calm   = 1'b0;
    choked = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 40 == 0) calm = ($urandom_range(3, 0) == 0);
      stall = calm ? 0 : $urandom_range(MAX_GAP, 0);
      if (flood && !choked) begin
        choked = 1'b1;
        stall  = CHOKE_CYCLES;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      taken++;
    end
  end

  function automatic in_item_t make_item(input op_t op, input logic din);
    in_item_t it;
    it.op             = op;
    it.ap_ndp         = 1'($urandom);
    it.read_not_write = 1'($urandom);
    it.reg_addr       = 2'($urandom);
    it.write_data     = $urandom;
    it.stop_on_error  = 1'($urandom);
    it.swdio_in       = din;
    return it;
  endfunction

  // Acknowledge as the target would send it: mostly OK, some WAIT and FAULT, some junk.
  function automatic logic [2:0] pick_ack();
    int r;
    r = $urandom_range(99, 0);
    if (r < 55) return ACK_OK;
    if (r < 80) return ACK_WAIT;
    if (r < 90) return ACK_FAULT;
    return 3'($urandom_range(7, 0));
  endfunction

  // Offers one item after a random gap and waits until it is taken.
  task automatic offer(input in_item_t it);
    int gap;
    gap = send_calm ? 0 : $urandom_range(MAX_GAP, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Clock ticks with random line levels; now and then a stray request the engine ignores.
  task automatic run_ticks(input int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(24, 0) == 0) offer(make_item(op_t'($urandom_range(3, 1)), 1'($urandom)));
      offer(make_item(OP_TICK, 1'($urandom)));
      counted++;
    end
  endtask

  task automatic send_ack(input logic [2:0] ack);
    for (int k = 0; k < 3; k++) begin
      offer(make_item(OP_TICK, ack[k]));
      counted++;
    end
  endtask

  // A complete transfer: header attempts until the ack is final, then the closing phase.
  task automatic run_transfer(input logic rnw, input logic halt, input logic [31:0] wd);
    in_item_t   it;
    logic [2:0] ack;
    logic [15:0] left;
    bit         more;
    it = make_item(OP_START, 1'($urandom));
    it.read_not_write = rnw;
    it.stop_on_error  = halt;
    it.write_data     = wd;
    offer(it);
    counted++;
    left = retry_cfg;
    more = 1'b1;
    while (more) begin
      run_ticks(9);
      ack = pick_ack();
      send_ack(ack);
      if (ack == ACK_WAIT && left != 16'd0) begin
        left = left - 16'd1;
        run_ticks(1);
      end else begin
        more = 1'b0;
        if (ack != ACK_OK && halt) run_ticks(1);
        else if (!rnw) run_ticks(34);
        else if (ack == ACK_WAIT) run_ticks(35);
        else run_ticks(34);
      end
    end
  endtask

  task automatic run_line_reset();
    offer(make_item(OP_LINE_RESET, 1'($urandom)));
    counted++;
    run_ticks(16 + HIGH_BITS + 2);
  endtask

  task automatic run_random_sequence();
    int          pick;
    logic [31:0] wd;
    pick = $urandom_range(19, 0);
    send_calm = ($urandom_range(3, 0) == 0);
    case ($urandom_range(7, 0))
      0:       wd = '0;
      1:       wd = '1;
      default: wd = $urandom;
    endcase
    if (pick < 16) begin
      run_transfer(1'($urandom), 1'($urandom), wd);
    end else if (pick < 18) begin
      run_line_reset();
    end else begin
      // Idle noise: ticks and unused operations that change nothing.
      repeat ($urandom_range(4, 1))
        offer(make_item(($urandom_range(1, 0) != 0) ? OP_UNUSED : OP_TICK, 1'($urandom)));
    end
  endtask

  // Retry limit writes happen only once every predicted item has arrived.
  task automatic write_retry_limit(input logic [15:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    retry_cfg = value;
  endtask

  initial begin : stimulus
    in_item_t it;
    int       budget;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    flood     <= 1'b0;
    retry_cfg = RETRY_RESET;
    counted   = 0;
    send_calm = 1'b0;
    retry_plan = '{16'd0, 16'd65535, 16'd1, 16'd3, 16'd600, 16'($urandom_range(5, 0))};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: ignored operations, a read that is halted by FAULT, a start and a line reset while busy.
    offer(make_item(OP_UNUSED, 1'b1));
    offer(make_item(OP_TICK, 1'b1));
    it = make_item(OP_START, 1'b1);
    it.ap_ndp         = 1'b1;
    it.read_not_write = 1'b1;
    it.reg_addr       = 2'd3;
    it.write_data     = '1;
    it.stop_on_error  = 1'b1;
    offer(it);
    counted++;
    it = make_item(OP_START, 1'b0);
    it.ap_ndp         = 1'b0;
    it.read_not_write = 1'b0;
    it.reg_addr       = 2'd0;
    it.write_data     = '0;
    it.stop_on_error  = 1'b0;
    offer(it);
    offer(make_item(OP_LINE_RESET, 1'b0));
    offer(make_item(OP_UNUSED, 1'b0));
    run_ticks(9);
    send_ack(ACK_FAULT);
    run_ticks(1);

    // Random phases, each under its own retry limit.
    for (int ph = 0; ph < 6; ph++) begin
      write_retry_limit(retry_plan[ph]);
      if (ph == 0) begin
        // Keep offering while the drain side holds off, so the engine backs up.
        send_calm = 1'b1;
        flood <= 1'b1;
        run_line_reset();
        flood <= 1'b0;
      end
      budget = ITEM_TARGET * (ph + 1) / 6;
      while (counted < budget) run_random_sequence();
    end

    // Drain everything, let the pipeline settle, then report.
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fails == 0) begin
      $display("** swd_host_transaction_engine_top: PASSED **");
    end else begin
      $display("** swd_host_transaction_engine_top: FAILED **");
    end
    $finish;
  end

endmodule
